FILE: rtl/igt_pkg.sv
// shared constants and types for the iterative global threshold block
`default_nettype none
package igt_pkg;
  localparam int unsigned MaxPixels = 1048576;
  localparam int unsigned MaxRounds = 256;
  localparam int unsigned CountW = 21;
  localparam int unsigned SumW = 29;
  localparam int unsigned RoundW = 9;

  localparam logic [1:0] StConverged = 2'd0;
  localparam logic [1:0] StSingle = 2'd1;
  localparam logic [1:0] StRoundLimit = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_pixel;
  } item_t;
endpackage
`default_nettype wire

FILE: rtl/igt_queue.sv
// two-entry item queue between the accepting front and the histogram back
`default_nettype none
module igt_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  igt_pkg::item_t     wr_item_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output igt_pkg::item_t     rd_item_o
);
  import igt_pkg::*;

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/igt_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module igt_divider (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [igt_pkg::SumW-1:0]    dividend_i,
  input  wire logic [igt_pkg::CountW-1:0]  divisor_i,
  output logic                             done_o,
  output logic [7:0]                       quot_o
);
  import igt_pkg::*;

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]   quo_q;
  logic [CountW:0]   rem_q;
  logic [CountW-1:0] div_q;
  logic [StepW-1:0]  step_q;
  logic              busy_q;
  logic [CountW:0]   shifted;
  logic              ge;

  assign shifted = {rem_q[CountW-1:0], quo_q[SumW-1]};
  assign ge = shifted >= {1'b0, div_q};
  assign quot_o = quo_q[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(SumW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? shifted - {1'b0, div_q} : shifted;
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

FILE: rtl/igt_back.sv
// histogram memory, range scan, isodata rounds and clearing sweep
`default_nettype none
module igt_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  igt_pkg::item_t     in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         threshold_o,
  output logic [1:0]         status_o
);
  import igt_pkg::*;

  typedef enum logic [9:0] {
    SInit   = 10'b0000000001,
    SRun    = 10'b0000000010,
    SScan   = 10'b0000000100,
    SRound  = 10'b0000001000,
    SDivLo  = 10'b0000010000,
    SDivHi  = 10'b0000100000,
    SDecide = 10'b0001000000,
    SOut    = 10'b0010000000,
    SClear  = 10'b0100000000,
    SFlush  = 10'b1000000000
  } state_e;

  state_e state_q;
  logic [CountW-1:0] hist_q [256];
  logic [CountW-1:0] rd_q;
  logic [7:0]  rd_addr, wr_addr;
  logic        wr_en;
  logic [CountW-1:0] wr_data;

  logic [CountW-1:0] seen_q;
  logic        inc_pend_q;
  logic [7:0]  inc_addr_q;
  logic [8:0]  idx_q;
  logic        rd_vld_q;
  logic [7:0]  rd_lv_q;
  logic        found_q;
  logic [7:0]  low_q, high_q, t_q;
  logic [SumW-1:0]   lo_sum_q, hi_sum_q;
  logic [CountW-1:0] lo_n_q, hi_n_q;
  logic [RoundW-1:0] rounds_q;
  logic [7:0]  lo_mean_q;
  logic [7:0]  res_t_q;
  logic [1:0]  res_s_q;
  logic        last_pend_q;

  logic              div_start, div_done;
  logic [SumW-1:0]   div_a;
  logic [CountW-1:0] div_b;
  logic [7:0]        div_q;
  logic [7:0]        nt;
  logic              accept;
  logic [SumW-1:0]   prod;

  igt_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a),
    .divisor_i(div_b), .done_o(div_done), .quot_o(div_q)
  );

  // run: read-modify-write pipeline, one pixel per cycle with forwarding
  assign in_ready_o = (state_q == SRun) && !last_pend_q;
  assign accept = in_valid_i && in_ready_o;
  assign rd_addr = (state_q == SRun) ? in_item_i.pixel : idx_q[7:0];

  logic [CountW-1:0] cur_cnt;
  assign cur_cnt = rd_q;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = inc_addr_q;
    wr_data = cur_cnt + 1'b1;
    if (state_q == SRun && inc_pend_q) begin
      wr_en = 1'b1;
    end else if (state_q == SInit || state_q == SClear) begin
      wr_en = 1'b1;
      wr_addr = idx_q[7:0];
      wr_data = '0;
    end
  end

  logic fwd;
  assign fwd = inc_pend_q && (inc_addr_q == rd_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) hist_q[wr_addr] <= wr_data;
    rd_q <= fwd ? wr_data : hist_q[rd_addr];
  end

  assign prod = rd_q * rd_lv_q;

  assign div_a = (state_q == SRound) ? lo_sum_q : hi_sum_q;
  assign div_b = (state_q == SRound) ? lo_n_q : hi_n_q;
  assign div_start = (state_q == SRound && !rd_vld_q && idx_q == 9'd256 && lo_n_q != '0)
                  || (state_q == SDivLo && (div_done || lo_n_q == '0));
  assign nt = 8'(({1'b0, lo_mean_q} + {1'b0, div_q}) >> 1);

  assign out_valid_o = (state_q == SOut);
  assign threshold_o = res_t_q;
  assign status_o = res_s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      idx_q <= '0;
      inc_pend_q <= 1'b0;
      last_pend_q <= 1'b0;
      seen_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        SInit, SClear: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == 9'd255) begin
            idx_q <= '0;
            state_q <= SRun;
            seen_q <= '0;
          end
        end
        SRun: begin
          inc_pend_q <= 1'b0;
          if (accept) begin
            if (seen_q < CountW'(MaxPixels)) begin
              inc_pend_q <= 1'b1;
              inc_addr_q <= in_item_i.pixel;
              seen_q <= seen_q + 1'b1;
            end
            last_pend_q <= in_item_i.last_pixel;
          end
          if (last_pend_q && !inc_pend_q) begin
            last_pend_q <= 1'b0;
            state_q <= SScan;
            idx_q <= '0;
            rd_vld_q <= 1'b0;
            found_q <= 1'b0;
            low_q <= '0;
            high_q <= '0;
          end
        end
        SScan: begin
          if (idx_q != 9'd256) idx_q <= idx_q + 1'b1;
          rd_vld_q <= (idx_q != 9'd256);
          rd_lv_q <= idx_q[7:0];
          if (rd_vld_q && rd_q != '0) begin
            if (!found_q) low_q <= rd_lv_q;
            high_q <= rd_lv_q;
            found_q <= 1'b1;
          end
          if (!rd_vld_q && idx_q == 9'd256) begin
            if (!found_q || low_q == high_q) begin
              res_t_q <= found_q ? low_q : 8'd0;
              res_s_q <= StSingle;
              state_q <= SOut;
            end else begin
              t_q <= 8'(({1'b0, low_q} + {1'b0, high_q}) >> 1);
              rounds_q <= '0;
              state_q <= SRound;
              idx_q <= '0;
              lo_sum_q <= '0; hi_sum_q <= '0; lo_n_q <= '0; hi_n_q <= '0;
            end
          end
        end
        SRound: begin
          if (idx_q != 9'd256) idx_q <= idx_q + 1'b1;
          rd_vld_q <= (idx_q != 9'd256);
          rd_lv_q <= idx_q[7:0];
          if (rd_vld_q) begin
            if (rd_lv_q < t_q) begin
              lo_sum_q <= lo_sum_q + prod;
              lo_n_q <= lo_n_q + rd_q;
            end else begin
              hi_sum_q <= hi_sum_q + prod;
              hi_n_q <= hi_n_q + rd_q;
            end
          end
          if (!rd_vld_q && idx_q == 9'd256) state_q <= SDivLo;
        end
        SDivLo: begin
          if (lo_n_q == '0 && !div_done) begin
            lo_mean_q <= t_q;
            state_q <= SDivHi;
          end else if (div_done) begin
            lo_mean_q <= div_q;
            state_q <= SDivHi;
          end
        end
        SDivHi: begin
          if (div_done) state_q <= SDecide;
        end
        SDecide: begin
          rounds_q <= rounds_q + 1'b1;
          if (nt == t_q) begin
            res_t_q <= t_q;
            res_s_q <= StConverged;
            state_q <= SOut;
          end else if (rounds_q == RoundW'(MaxRounds - 1)) begin
            res_t_q <= nt;
            res_s_q <= StRoundLimit;
            state_q <= SOut;
          end else begin
            t_q <= nt;
            state_q <= SRound;
            idx_q <= '0;
            lo_sum_q <= '0; hi_sum_q <= '0; lo_n_q <= '0; hi_n_q <= '0;
          end
        end
        SOut: begin
          if (out_ready_i) begin
            state_q <= SClear;
            idx_q <= '0;
          end
        end
        SFlush: state_q <= SRun;
        default: state_q <= SInit;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/iterative_global_threshold.sv
// top level of the iterative global threshold block
// sequence: pixels stream in one per cycle; after the last pixel, a range scan,
// then, if two or more levels occur, rounds of a sweep, a low-mean division
// (skipped if the low class is empty), a high-mean division and a decision
// throughput: one pixel per cycle while counting; search and histogram clear
// set the time between images; a clearing pass at reset precedes the first item
`default_nettype none
module iterative_global_threshold (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // pixel
  input  wire logic       s_axis_tlast,   // last_pixel
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [15:0]     m_axis_tdata    // threshold, status, zero fill
);
  import igt_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_ready;
  logic [7:0] thr;
  logic [1:0] st;

  assign in_item.pixel = s_axis_tdata;
  assign in_item.last_pixel = s_axis_tlast;

  igt_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(s_axis_tvalid), .wr_ready_o(s_axis_tready), .wr_item_i(in_item),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_item_o(q_item)
  );

  igt_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .threshold_o(thr), .status_o(st)
  );

  assign m_axis_tdata = {6'd0, st, thr};
endmodule
`default_nettype wire
